/* sv/vaptbl_pkg.sv */
// Shared types and codes for the virtual access point table.
// No dependencies; imported by the table top level, the checker and the bench.
package vaptbl_pkg;

	localparam int ADDR_W  = 48;
	localparam int TIME_W  = 32;
	localparam int LIMIT_W = 16;
	localparam int REQ_W   = 3;
	localparam int STAT_W  = 3;
	localparam int IDX_W   = 4;
	localparam int CNT_W   = 5;
	localparam int CFG_W   = 48;
	localparam int CFGA_W  = 1;

	// request codes
	localparam logic [REQ_W-1:0] REQ_ADD    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
	localparam logic [REQ_W-1:0] REQ_LOOKUP = 3'd2;
	localparam logic [REQ_W-1:0] REQ_SWEEP  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_MARK   = 3'd4;

	// result status codes
	localparam logic [STAT_W-1:0] ST_ADDED    = 3'd0;
	localparam logic [STAT_W-1:0] ST_PRESENT  = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
	localparam logic [STAT_W-1:0] ST_REMOVED  = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;
	localparam logic [STAT_W-1:0] ST_FOUND    = 3'd5;
	localparam logic [STAT_W-1:0] ST_SWEPT    = 3'd6;
	localparam logic [STAT_W-1:0] ST_MARKED   = 3'd7;

	// configuration register indexes
	localparam logic [CFGA_W-1:0] CFG_OWN_ADDR  = 1'd0;
	localparam logic [CFGA_W-1:0] CFG_AGE_LIMIT = 1'd1;

	localparam logic [LIMIT_W-1:0] AGE_LIMIT_RST = 16'd60;

	// one table slot as stored in the slot RAM
	typedef struct packed {
		logic              beacon;
		logic [TIME_W-1:0] created;
		logic [ADDR_W-1:0] bssid;
		logic [ADDR_W-1:0] addr;
	} slot_rec_t;

endpackage

/* sv/vaptbl_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module vaptbl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sv/vap_table_with_aging_and_bssid_mask.sv */
// Virtual access point table with age sweep and BSSID mask recompute.
// Depends on vaptbl_pkg and instantiates vaptbl_ram for the slot contents.
//
//  channel | signals                                      | direction | handshake
//  --------+----------------------------------------------+-----------+----------
//  req     | req_type vap_address bss_id now_seconds      | in        | req_valid/req_ready
//  rsp     | status hit entry_index found_bssid found_time| out       | rsp_valid/rsp_ready
//          | removed_count bss_mask                       |           |
//  cfg     | cfg_addr cfg_wdata                           | in        | cfg_wr_en, no wait
//
// Each item is accepted from idle, walks the slot RAM's single read port at one slot a cycle
// with registered read data, and then commits the update and loads the result register.
// The per-slot key compare, age subtract and mask AND form one unit reused each cycle.
// Reset clears valid bits, rsp_valid, own_q; mask all ones, age limit 60; RAM contents stay.
// A result waiting on rsp_ready holds the commit cycle; req_ready is low until it ends.
module vap_table_with_aging_and_bssid_mask #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// request channel
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic [vaptbl_pkg::REQ_W-1:0] req_type,
	input  logic [vaptbl_pkg::ADDR_W-1:0] vap_address,
	input  logic [vaptbl_pkg::ADDR_W-1:0] bss_id,
	input  logic [vaptbl_pkg::TIME_W-1:0] now_seconds,
	// result channel
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [vaptbl_pkg::STAT_W-1:0] status,
	output logic                          hit,
	output logic [vaptbl_pkg::IDX_W-1:0]  entry_index,
	output logic [vaptbl_pkg::ADDR_W-1:0] found_bssid,
	output logic [vaptbl_pkg::TIME_W-1:0] found_time,
	output logic [vaptbl_pkg::CNT_W-1:0]  removed_count,
	output logic [vaptbl_pkg::ADDR_W-1:0] bss_mask,
	// configuration write port
	input  logic                          cfg_wr_en,
	input  logic [vaptbl_pkg::CFGA_W-1:0] cfg_addr,
	input  logic [vaptbl_pkg::CFG_W-1:0]  cfg_wdata
);
	import vaptbl_pkg::*;

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int RW = $bits(slot_rec_t);
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
	localparam logic [CW-1:0] N_SLOTS  = CW'(TABLE_ENTRIES);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_COMMIT
	} state_t;

	state_t state_q;

	// configuration
	logic [ADDR_W-1:0]  own_q;
	logic [LIMIT_W-1:0] limit_q;

	// table control and mask
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [ADDR_W-1:0]        mask_q;

	// captured item
	logic [REQ_W-1:0]  req_q;
	logic [ADDR_W-1:0] key_q;
	logic [ADDR_W-1:0] bss_q;
	logic [TIME_W-1:0] now_q;

	// walk
	logic [CW-1:0] iss_q;
	logic          rd_s1;
	logic [IW-1:0] idx_s1;

	// walk results
	logic              match_q;
	logic [IW-1:0]     match_idx_q;
	slot_rec_t         match_rec_q;
	logic              free_q;
	logic [IW-1:0]     free_idx_q;
	logic [CW-1:0]     swept_q;
	logic [ADDR_W-1:0] acc_q;

	// RAM ports
	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	slot_rec_t     ram_wrec;
	logic          ram_re;
	logic [RW-1:0] ram_rdata;
	slot_rec_t     rd_rec;

	// per-slot unit
	logic              slot_v;
	logic              key_hit;
	logic [TIME_W:0]   age;
	logic              too_old;
	logic              keep;
	logic [ADDR_W-1:0] add_mask;
	logic              out_free;

	// result fields and table update chosen at commit
	logic [STAT_W-1:0] res_status;
	logic              res_hit;
	logic [IDX_W-1:0]  res_index;
	logic [ADDR_W-1:0] res_bssid;
	logic [TIME_W-1:0] res_time;
	logic [CNT_W-1:0]  res_removed;
	logic [ADDR_W-1:0] res_mask;
	logic              set_valid;
	logic              clr_valid;

	assign ram_re = (state_q == S_SCAN) && (iss_q < N_SLOTS);
	assign rd_rec = ram_rdata;

	// compare, age and mask unit applied to the slot read in the previous cycle
	assign slot_v  = valid_q[idx_s1];
	assign key_hit = slot_v && (rd_rec.addr == key_q);
	assign age     = {1'b0, now_q} - {1'b0, rd_rec.created};
	assign too_old = slot_v && !rd_rec.beacon && !age[TIME_W]
	                 && (age[TIME_W-1:0] > {{(TIME_W-LIMIT_W){1'b0}}, limit_q});
	assign keep    = slot_v && !((req_q == REQ_REMOVE) && key_hit)
	                 && !((req_q == REQ_SWEEP) && too_old);

	// mask with a freshly added entry folded in
	assign add_mask = acc_q & ~(own_q ^ bss_q);

	assign out_free = !rsp_valid || rsp_ready;

	// write port: a new entry on add, the flagged record on mark
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = free_idx_q;
		ram_wrec  = '{beacon: 1'b0, created: now_q, bssid: bss_q, addr: key_q};
		if (state_q == S_COMMIT && out_free) begin
			if (req_q == REQ_ADD && !match_q && free_q) begin
				ram_we = 1'b1;
			end else if (req_q == REQ_MARK && match_q) begin
				ram_we           = 1'b1;
				ram_waddr        = match_idx_q;
				ram_wrec         = match_rec_q;
				ram_wrec.beacon  = 1'b1;
			end
		end
	end

	// decode the walk results into the result fields; misses and unused codes
	// fall through as not found with only the mask reported
	always_comb begin
		res_status  = ST_NOTFOUND;
		res_hit     = 1'b0;
		res_index   = '0;
		res_bssid   = '0;
		res_time    = '0;
		res_removed = '0;
		res_mask    = mask_q;
		set_valid   = 1'b0;
		clr_valid   = 1'b0;
		case (req_q)
			REQ_ADD: begin
				if (match_q) begin
					// present key: report it, leave entry and mask alone
					res_status = ST_PRESENT;
					res_hit    = 1'b1;
					res_index  = IDX_W'(match_idx_q);
					res_bssid  = match_rec_q.bssid;
					res_time   = match_rec_q.created;
				end else if (!free_q) begin
					res_status = ST_FULL;
				end else begin
					set_valid  = 1'b1;
					res_mask   = add_mask;
					res_status = ST_ADDED;
					res_hit    = 1'b1;
					res_index  = IDX_W'(free_idx_q);
					res_bssid  = bss_q;
					res_time   = now_q;
				end
			end
			REQ_REMOVE: begin
				// recompute the mask even on a miss
				res_mask = acc_q;
				if (match_q) begin
					clr_valid   = 1'b1;
					res_status  = ST_REMOVED;
					res_index   = IDX_W'(match_idx_q);
					res_bssid   = match_rec_q.bssid;
					res_time    = match_rec_q.created;
					res_removed = CNT_W'(1);
				end
			end
			REQ_LOOKUP: begin
				if (match_q) begin
					res_status = ST_FOUND;
					res_hit    = 1'b1;
					res_index  = IDX_W'(match_idx_q);
					res_bssid  = match_rec_q.bssid;
					res_time   = match_rec_q.created;
				end
			end
			REQ_SWEEP: begin
				res_mask    = acc_q;
				res_status  = ST_SWEPT;
				res_removed = CNT_W'(swept_q);
			end
			REQ_MARK: begin
				if (match_q) begin
					res_status = ST_MARKED;
					res_hit    = 1'b1;
					res_index  = IDX_W'(match_idx_q);
					res_bssid  = match_rec_q.bssid;
					res_time   = match_rec_q.created;
				end
			end
			default: ;
		endcase
	end

	vaptbl_ram #(
		.WIDTH(RW),
		.DEPTH(TABLE_ENTRIES),
		.AW   (IW)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wrec),
		.re   (ram_re),
		.raddr(iss_q[IW-1:0]),
		.rdata(ram_rdata)
	);

	assign req_ready = (state_q == S_IDLE);

	// configuration registers: the user must write them only while idle; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q   <= '0;
			limit_q <= AGE_LIMIT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				CFG_OWN_ADDR:  own_q   <= cfg_wdata[ADDR_W-1:0];
				CFG_AGE_LIMIT: limit_q <= cfg_wdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			valid_q   <= '0;
			mask_q    <= '1;
			rsp_valid <= 1'b0;
			rd_s1     <= 1'b0;
		end else begin
			// drop a taken result unless the commit loads a new one this cycle
			if (rsp_valid && rsp_ready && state_q != S_COMMIT) begin
				rsp_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						// latch the item and clear the walk results
						req_q   <= req_type;
						key_q   <= vap_address;
						bss_q   <= bss_id;
						now_q   <= now_seconds;
						iss_q   <= '0;
						rd_s1   <= 1'b0;
						match_q <= 1'b0;
						free_q  <= 1'b0;
						swept_q <= '0;
						acc_q   <= '1;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// issue one read per cycle, process the previous one
					rd_s1 <= ram_re;
					if (ram_re) begin
						idx_s1 <= iss_q[IW-1:0];
						iss_q  <= iss_q + CW'(1);
					end
					if (rd_s1) begin
						if (key_hit && !match_q) begin
							match_q     <= 1'b1;
							match_idx_q <= idx_s1;
							match_rec_q <= rd_rec;
						end
						if (!slot_v && !free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= idx_s1;
						end
						if (req_q == REQ_SWEEP && too_old) begin
							valid_q[idx_s1] <= 1'b0;
							swept_q         <= swept_q + CW'(1);
						end
						if (keep) begin
							acc_q <= acc_q & ~(own_q ^ rd_rec.bssid);
						end
						if (idx_s1 == LAST_IDX) begin
							state_q <= S_COMMIT;
						end
					end
				end
				S_COMMIT: begin
					// hold until the result register is free
					if (out_free) begin
						rsp_valid     <= 1'b1;
						status        <= res_status;
						hit           <= res_hit;
						entry_index   <= res_index;
						found_bssid   <= res_bssid;
						found_time    <= res_time;
						removed_count <= res_removed;
						bss_mask      <= res_mask;
						mask_q        <= res_mask;
						state_q       <= S_IDLE;
						if (set_valid) begin
							valid_q[free_idx_q] <= 1'b1;
						end else if (clr_valid) begin
							valid_q[match_idx_q] <= 1'b0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* sv/vaptbl_chk.sv */
// Port-level checker for the virtual access point table, bound to its top level.
// Depends on vaptbl_pkg and vap_table_with_aging_and_bssid_mask.
module vaptbl_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [vaptbl_pkg::STAT_W-1:0] status,
	input logic                          hit,
	input logic [vaptbl_pkg::IDX_W-1:0]  entry_index,
	input logic [vaptbl_pkg::ADDR_W-1:0] found_bssid,
	input logic [vaptbl_pkg::CNT_W-1:0]  removed_count,
	input logic [vaptbl_pkg::ADDR_W-1:0] bss_mask
);
	import vaptbl_pkg::*;

	// a stalled result holds its status and mask
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(bss_mask))
		else $error("result changed while stalled");

	// the table walk keeps the request side closed after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted during a walk");

	// a removal reports exactly one deleted entry and no hit
	a_remove: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_REMOVED |-> !hit && removed_count == CNT_W'(1))
		else $error("bad removal result");

	// a sweep reports no entry fields
	a_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_SWEPT |-> !hit && entry_index == '0 && found_bssid == '0)
		else $error("bad sweep result");

endmodule

bind vap_table_with_aging_and_bssid_mask vaptbl_chk u_vaptbl_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req_valid),
	.req_ready    (req_ready),
	.rsp_valid    (rsp_valid),
	.rsp_ready    (rsp_ready),
	.status       (status),
	.hit          (hit),
	.entry_index  (entry_index),
	.found_bssid  (found_bssid),
	.removed_count(removed_count),
	.bss_mask     (bss_mask)
);

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for the virtual access point table: add, remove, lookup, age sweep,
// mark beacon and the BSSID mask. Depends on vaptbl_pkg and the table top level.
module tb_top;
	import vaptbl_pkg::*;

	localparam int SLOTS          = 16;
	localparam int KEY_POOL       = 20;
	localparam int DRAIN_CYCLES   = 2 * (SLOTS + 3);
	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 4000;

	// request codes the block does not decode; it answers them as not found
	localparam logic [REQ_W-1:0] REQ_RSVD_A = 3'd5;
	localparam logic [REQ_W-1:0] REQ_RSVD_B = 3'd6;
	localparam logic [REQ_W-1:0] REQ_RSVD_C = 3'd7;

	typedef struct packed {
		logic [REQ_W-1:0]  kind;
		logic [ADDR_W-1:0] key;
		logic [ADDR_W-1:0] bss;
		logic [TIME_W-1:0] now;
	} vap_req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              hit;
		logic [IDX_W-1:0]  index;
		logic [ADDR_W-1:0] bssid;
		logic [TIME_W-1:0] born;
		logic [CNT_W-1:0]  removed;
		logic [ADDR_W-1:0] mask;
	} vap_result_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                req_valid;
	logic                req_ready;
	logic [REQ_W-1:0]    req_type;
	logic [ADDR_W-1:0]   vap_address;
	logic [ADDR_W-1:0]   bss_id;
	logic [TIME_W-1:0]   now_seconds;
	logic                rsp_valid;
	logic                rsp_ready;
	logic [STAT_W-1:0]   status;
	logic                hit;
	logic [IDX_W-1:0]    entry_index;
	logic [ADDR_W-1:0]   found_bssid;
	logic [TIME_W-1:0]   found_time;
	logic [CNT_W-1:0]    removed_count;
	logic [ADDR_W-1:0]   bss_mask;
	logic                cfg_wr_en;
	logic [CFGA_W-1:0]   cfg_addr;
	logic [CFG_W-1:0]    cfg_wdata;

	// Local copy of the table and its registers, kept in step with every accepted item.
	bit                  slot_used   [SLOTS];
	bit                  slot_pinned [SLOTS];
	logic [ADDR_W-1:0]   slot_key    [SLOTS];
	logic [ADDR_W-1:0]   slot_bss    [SLOTS];
	logic [TIME_W-1:0]   slot_born   [SLOTS];
	logic [ADDR_W-1:0]   model_mask  = '1;
	logic [ADDR_W-1:0]   model_own   = '0;
	logic [LIMIT_W-1:0]  model_limit = AGE_LIMIT_RST;

	vap_result_t         replies_due [$];
	int                  errors       = 0;
	int                  quiet_cycles = 0;
	int                  hold_request = 0;
	bit                  src_idle_on  = 1'b0;
	bit                  sink_idle_on = 1'b0;

	vap_table_with_aging_and_bssid_mask DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.req_type      (req_type),
		.vap_address   (vap_address),
		.bss_id        (bss_id),
		.now_seconds   (now_seconds),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.status        (status),
		.hit           (hit),
		.entry_index   (entry_index),
		.found_bssid   (found_bssid),
		.found_time    (found_time),
		.removed_count (removed_count),
		.bss_mask      (bss_mask),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [ADDR_W-1:0] rand48();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[ADDR_W-1:0];
	endfunction

	function automatic vap_req_t mk_req(logic [REQ_W-1:0] kind, logic [ADDR_W-1:0] key,
			logic [ADDR_W-1:0] bss, logic [TIME_W-1:0] now);
		vap_req_t rq;
		rq.kind = kind;
		rq.key  = key;
		rq.bss  = bss;
		rq.now  = now;
		return rq;
	endfunction

	function automatic int find_key(logic [ADDR_W-1:0] key);
		for (int i = 0; i < SLOTS; i++)
			if (slot_used[i] && slot_key[i] == key)
				return i;
		return -1;
	endfunction

	function automatic int first_free();
		for (int i = 0; i < SLOTS; i++)
			if (!slot_used[i])
				return i;
		return -1;
	endfunction

	// AND together NOT(own XOR bssid) over every live slot; an empty table gives all ones.
	function automatic void recalc_mask();
		logic [ADDR_W-1:0] m;
		m = '1;
		for (int i = 0; i < SLOTS; i++)
			if (slot_used[i])
				m &= ~(model_own ^ slot_bss[i]);
		model_mask = m;
	endfunction

	function automatic vap_result_t slot_result(logic [STAT_W-1:0] st, logic h, int s);
		vap_result_t r;
		r         = '0;
		r.status  = st;
		r.hit     = h;
		r.index   = IDX_W'(s);
		r.bssid   = slot_bss[s];
		r.born    = slot_born[s];
		return r;
	endfunction

	// Apply one request to the local table and return the reply it must produce.
	function automatic vap_result_t table_reply(vap_req_t rq);
		vap_result_t r;
		int          s;
		int          n;
		longint      age;
		r        = '0;
		r.status = ST_NOTFOUND;
		s        = find_key(rq.key);
		case (rq.kind)
			REQ_ADD: begin
				if (s >= 0) begin
					// present key: report it, leave entry and mask alone
					r = slot_result(ST_PRESENT, 1'b1, s);
				end else begin
					s = first_free();
					if (s < 0) begin
						r.status = ST_FULL;
					end else begin
						slot_used[s]   = 1'b1;
						slot_pinned[s] = 1'b0;
						slot_key[s]    = rq.key;
						slot_bss[s]    = rq.bss;
						slot_born[s]   = rq.now;
						recalc_mask();
						r = slot_result(ST_ADDED, 1'b1, s);
					end
				end
			end
			REQ_REMOVE: begin
				if (s >= 0) begin
					r         = slot_result(ST_REMOVED, 1'b0, s);
					r.removed = CNT_W'(1);
					slot_used[s] = 1'b0;
				end
				// a miss still recomputes the mask
				recalc_mask();
			end
			REQ_LOOKUP: begin
				if (s >= 0)
					r = slot_result(ST_FOUND, 1'b1, s);
			end
			REQ_SWEEP: begin
				n = 0;
				for (int i = 0; i < SLOTS; i++) begin
					if (slot_used[i] && !slot_pinned[i]) begin
						// signed age: a time before creation is never old
						age = longint'(rq.now) - longint'(slot_born[i]);
						if (age > longint'(model_limit)) begin
							slot_used[i] = 1'b0;
							n++;
						end
					end
				end
				recalc_mask();
				r.status  = ST_SWEPT;
				r.removed = CNT_W'(n);
			end
			REQ_MARK: begin
				if (s >= 0) begin
					slot_pinned[s] = 1'b1;
					r = slot_result(ST_MARKED, 1'b1, s);
				end
			end
			default: ;
		endcase
		r.mask = model_mask;
		return r;
	endfunction

	// Offer one item, optionally after a random gap, and hold it until accepted.
	// Valid stays high on return so a following item can go out without a bubble.
	task automatic send_req(input vap_req_t rq);
		if (src_idle_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		req_valid   <= 1'b1;
		req_type    <= rq.kind;
		vap_address <= rq.key;
		bss_id      <= rq.bss;
		now_seconds <= rq.now;
		do @(posedge clk); while (!req_ready);
		replies_due.push_back(table_reply(rq));
	endtask

	// Drop valid, wait for every reply, then let the block settle.
	task automatic drain_results();
		req_valid <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write both registers back to back; only legal while idle.
	task automatic cfg_set(input logic [ADDR_W-1:0] own, input logic [LIMIT_W-1:0] limit);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= CFG_OWN_ADDR;
		cfg_wdata <= CFG_W'(own);
		@(posedge clk);
		cfg_addr  <= CFG_AGE_LIMIT;
		cfg_wdata <= CFG_W'(limit);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		model_own   = own;
		model_limit = limit;
	endtask

	// Reset values of the registers; every operation, misses, an unused code,
	// extreme keys and times, and a sweep at a time before an entry's creation.
	task automatic test_basic_ops();
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
		send_req(mk_req(REQ_LOOKUP, '0, '0, '0));
		send_req(mk_req(REQ_REMOVE, '0, '1, '1));
		send_req(mk_req(REQ_ADD, '0, '0, '0));
		send_req(mk_req(REQ_ADD, '1, '1, '1));
		send_req(mk_req(REQ_ADD, '0, rand48(), 32'd5));
		send_req(mk_req(REQ_LOOKUP, '1, rand48(), $urandom));
		send_req(mk_req(REQ_MARK, '0, rand48(), $urandom));
		send_req(mk_req(REQ_MARK, 48'h0000_0000_0001, rand48(), $urandom));
		send_req(mk_req(REQ_RSVD_A, '1, rand48(), $urandom));
		send_req(mk_req(REQ_SWEEP, rand48(), rand48(), '0));
		send_req(mk_req(REQ_REMOVE, '1, rand48(), $urandom));
		drain_results();
	endtask

	// Fill the table to overflow, then sweep exactly at and one past the limit.
	// The beaconing entry left over from the basic test must survive.
	task automatic test_full_and_sweep();
		cfg_set('1, '0);
		for (int i = 1; i <= SLOTS; i++)
			send_req(mk_req(REQ_ADD, ADDR_W'(i) * 48'h0102_0304_0506, rand48(), 32'd100));
		send_req(mk_req(REQ_SWEEP, rand48(), rand48(), 32'd100));
		send_req(mk_req(REQ_SWEEP, rand48(), rand48(), 32'd101));
		drain_results();
	endtask

	// Random mix over a small key pool so adds, hits, full table and sweeps all recur.
	task automatic test_random_traffic(input int n_items, input logic [ADDR_W-1:0] own,
			input logic [LIMIT_W-1:0] limit, input bit idle);
		logic [ADDR_W-1:0] pool [KEY_POOL];
		logic [TIME_W-1:0] clock_s;
		vap_req_t          rq;
		int                counted;
		int                pick;
		int                step_max;
		cfg_set(own, limit);
		src_idle_on  = idle;
		sink_idle_on = idle;
		foreach (pool[k])
			pool[k] = rand48();
		clock_s  = $urandom_range(0, 1000);
		step_max = int'(limit) / 4 + 3;
		counted  = 0;
		while (counted < n_items) begin
			pick   = $urandom_range(0, 99);
			rq.key = pool[$urandom_range(0, KEY_POOL - 1)];
			// half the BSSIDs sit a few bits away from our own address so the mask keeps ones
			rq.bss = ($urandom_range(0, 1) == 0) ? rand48() : own ^ (rand48() & rand48() & rand48());
			rq.now = $urandom;
			// advance the clock; now and then jump anywhere, backward included
			if ($urandom_range(0, 49) == 0)
				clock_s = $urandom;
			else
				clock_s += $urandom_range(0, step_max);
			if (pick < 35) begin
				rq.kind = REQ_ADD;
				rq.now  = clock_s;
			end else if (pick < 50) begin
				rq.kind = REQ_REMOVE;
			end else if (pick < 68) begin
				rq.kind = REQ_LOOKUP;
			end else if (pick < 80) begin
				rq.kind = REQ_MARK;
			end else if (pick < 92) begin
				rq.kind = REQ_SWEEP;
				rq.now  = clock_s;
			end else if (pick < 97) begin
				rq.kind = ($urandom_range(0, 1) == 0) ? REQ_LOOKUP : REQ_REMOVE;
				rq.key  = rand48();
			end else begin
				case ($urandom_range(0, 2))
					0:       rq.kind = REQ_RSVD_A;
					1:       rq.kind = REQ_RSVD_B;
					default: rq.kind = REQ_RSVD_C;
				endcase
			end
			send_req(rq);
			if (rq.kind <= REQ_MARK)
				counted++;
		end
		drain_results();
	endtask

	// Hold off the result side for a long stretch while items keep coming.
	task automatic test_output_backpressure();
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		hold_request = LONG_HOLD;
		for (int i = 0; i < 8; i++)
			send_req(mk_req((i % 2 == 0) ? REQ_ADD : REQ_LOOKUP, rand48(), rand48(), $urandom));
		drain_results();
	endtask

	// Result side: ready by default, random stall bursts when enabled, and a long hold
	// counted here when a test asks for one.
	initial begin : rsp_sink
		int n;
		rsp_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				n            = hold_request;
				hold_request = 0;
				rsp_ready <= 1'b0;
				repeat (n) @(posedge clk);
				rsp_ready <= 1'b1;
			end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				rsp_ready <= 1'b1;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
			input logic [ADDR_W-1:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
		end
	endtask

	// Compare each accepted reply with the oldest one due.
	always @(posedge clk) begin : result_check
		vap_result_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (replies_due.size() == 0) begin
				errors++;
				$display("%0t: reply with none due, status %h mask %h", $time, status, bss_mask);
			end else begin
				want = replies_due.pop_front();
				check_field("status", want.status, status);
				check_field("hit", want.hit, hit);
				check_field("entry_index", want.index, entry_index);
				check_field("found_bssid", want.bssid, found_bssid);
				check_field("found_time", want.born, found_time);
				check_field("removed_count", want.removed, removed_count);
				check_field("bss_mask", want.mask, bss_mask);
			end
		end
	end

	// End the run if neither channel moves for too long.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		arst_n      <= 1'b0;
		req_valid   <= 1'b0;
		req_type    <= REQ_LOOKUP;
		vap_address <= '0;
		bss_id      <= '0;
		now_seconds <= '0;
		cfg_wr_en   <= 1'b0;
		cfg_addr    <= CFG_OWN_ADDR;
		cfg_wdata   <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ops();
		test_full_and_sweep();
		test_random_traffic(280, rand48(), '1, 1'b1);
		test_output_backpressure();
		test_random_traffic(230, rand48(), LIMIT_W'($urandom_range(1, 200)), 1'b1);
		test_random_traffic(230, '0, '0, 1'b1);
		// last stretch runs without idling on either side
		test_random_traffic(230, rand48(), LIMIT_W'($urandom), 1'b0);

		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
